// File: rtl/assert_macros.svh
// Assertion macros used by the RTL of the PCM resampler.
// Depends on nothing; each macro samples on i_clk and is off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pcm_lrs_pkg.sv
// Package for the PCM channel map and linear resampler.
// Holds the sequencer state type and the configuration register indexes; no dependencies.
package pcm_lrs_pkg;

    // Configuration register index
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_STEREO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_STEREO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC  = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ISSUE_L,
        S_ISSUE_R,
        S_CAP_L,
        S_EMIT
    } t_state;

endpackage

// File: rtl/pcm_channel_map_linear_resampler.sv
// Each result word passes CHECK, ISSUE_L, ISSUE_R, CAP_L and EMIT, using one shared multiplier
// (used for left then right, two pipeline stages); EMIT waits while the output register holds a
// stalled word. Up to 16 results per input word.
// The input stalls for the whole item; the output register lets the next word in early.
// Reset (synchronous, active low) clears config to mono/mono/1.0 and empties the stream.
module pcm_channel_map_linear_resampler #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [pcm_lrs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [FRAC_BITS+3:0]                 i_cfg_data,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]        i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0]        i_right_sample,
    input  logic                                 i_last_frame,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]        o_out_left,
    output logic signed [SAMPLE_BITS-1:0]        o_out_right,
    output logic                                 o_run_last,
    output logic                                 o_stream_end
);

    import pcm_lrs_pkg::*;

    `include "assert_macros.svh"

    localparam int SB = SAMPLE_BITS;
    localparam int F  = FRAC_BITS;
    localparam int IW = F + 4;
    localparam int PW = F + 5;

    localparam logic [PW-1:0] ONE_POS = {{(PW-1){1'b0}}, 1'b1} << F;
    localparam logic [PW-1:0] TWO_POS = {{(PW-1){1'b0}}, 1'b1} << (F + 1);
    localparam logic [IW-1:0] INC_MIN = {{(IW-1){1'b0}}, 1'b1} << (F - 3);
    localparam logic [IW-1:0] INC_MAX = {{(IW-1){1'b0}}, 1'b1} << (F + 3);
    localparam logic [IW-1:0] INC_RST = {{(IW-1){1'b0}}, 1'b1} << F;

    // configuration
    logic              r_in_stereo;
    logic              r_out_stereo;
    logic [IW-1:0]     r_inc_cfg;

    // sequencer and stream state
    t_state            r_state, n_state;
    logic              r_have_prev, n_have_prev;
    logic [PW-1:0]     r_pos, n_pos;
    logic signed [SB-1:0] r_prev_l, n_prev_l, r_prev_r, n_prev_r;
    logic signed [SB-1:0] r_cur_l, n_cur_l, r_cur_r, n_cur_r;
    logic              r_last, n_last;
    logic              r_flush, n_flush;
    logic [IW-1:0]     r_inc, n_inc;
    logic signed [SB-1:0] r_res_l, n_res_l;

    // output register
    logic              r_out_vld, n_out_vld;
    logic signed [SB-1:0] r_out_l, n_out_l, r_out_r, n_out_r;
    logic              r_out_rl, n_out_rl;
    logic              r_out_se, n_out_se;

    // datapath helpers
    logic              in_acc;
    logic [SB:0]       sum_lr;
    logic [SB:0]       sum_adj;
    logic signed [SB-1:0] map_l, map_r;
    logic [IW-1:0]     inc_clamp;
    logic [PW-1:0]     nxt_pos;
    logic              fin;
    logic              lu_vld;
    logic signed [SB-1:0] lu_a, lu_b, lu_res;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_stereo  <= 1'b0;
            r_out_stereo <= 1'b0;
            r_inc_cfg    <= INC_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IN_STEREO:  r_in_stereo  <= i_cfg_data[0];
                CFG_OUT_STEREO: r_out_stereo <= i_cfg_data[0];
                CFG_PHASE_INC:  r_inc_cfg    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Channel map: stereo to mono halves the sum toward zero
    assign sum_lr  = {i_left_sample[SB-1], i_left_sample}
                   + {i_right_sample[SB-1], i_right_sample};
    assign sum_adj = sum_lr + {{SB{1'b0}}, sum_lr[SB]};

    always_comb begin
        if (r_in_stereo) begin
            if (r_out_stereo) begin
                map_l = i_left_sample;
                map_r = i_right_sample;
            end else begin
                map_l = sum_adj[SB:1];
                map_r = '0;
            end
        end else begin
            map_l = i_left_sample;
            map_r = r_out_stereo ? i_left_sample : '0;
        end
    end

    // Clamp the increment to [1/8, 8] frames
    always_comb begin
        if (r_inc_cfg < INC_MIN) begin
            inc_clamp = INC_MIN;
        end else if (r_inc_cfg > INC_MAX) begin
            inc_clamp = INC_MAX;
        end else begin
            inc_clamp = r_inc_cfg;
        end
    end

    // Next position and whether this word ends the item
    assign nxt_pos = r_pos + {1'b0, r_inc};
    assign fin     = r_flush ? (nxt_pos >= ONE_POS)
                             : ((nxt_pos >= ONE_POS) && (!r_last || (nxt_pos >= TWO_POS)));

    // Shared unit operands: left in ISSUE_L, right in ISSUE_R
    assign lu_vld = (r_state == S_ISSUE_L) || (r_state == S_ISSUE_R);
    assign lu_a   = (r_state == S_ISSUE_R) ? r_prev_r : r_prev_l;
    assign lu_b   = (r_state == S_ISSUE_R) ? r_cur_r  : r_cur_l;

    pcm_lrs_lerp #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_lerp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (lu_vld),
        .i_a    (lu_a),
        .i_b    (lu_b),
        .i_frac (r_pos[F-1:0]),
        .o_res  (lu_res)
    );

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have_prev <= 1'b0;
            r_pos       <= '0;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
            r_flush     <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_have_prev <= n_have_prev;
            r_pos       <= n_pos;
            r_prev_l    <= n_prev_l;
            r_prev_r    <= n_prev_r;
            r_flush     <= n_flush;
            r_out_vld   <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur_l  <= n_cur_l;
        r_cur_r  <= n_cur_r;
        r_last   <= n_last;
        r_inc    <= n_inc;
        r_res_l  <= n_res_l;
        r_out_l  <= n_out_l;
        r_out_r  <= n_out_r;
        r_out_rl <= n_out_rl;
        r_out_se <= n_out_se;
    end

    // Next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_have_prev = r_have_prev;
        n_pos       = r_pos;
        n_prev_l    = r_prev_l;
        n_prev_r    = r_prev_r;
        n_cur_l     = r_cur_l;
        n_cur_r     = r_cur_r;
        n_last      = r_last;
        n_flush     = r_flush;
        n_inc       = r_inc;
        n_res_l     = r_res_l;
        n_out_vld   = r_out_vld;
        n_out_l     = r_out_l;
        n_out_r     = r_out_r;
        n_out_rl    = r_out_rl;
        n_out_se    = r_out_se;

        // drop the output word once taken
        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cur_l = map_l;
                    n_cur_r = map_r;
                    n_last  = i_last_frame;
                    n_inc   = inc_clamp;
                    n_flush = 1'b0;
                    if (!r_have_prev) begin
                        // first frame: store it, flush only if it also ends the stream
                        n_have_prev = 1'b1;
                        n_pos       = '0;
                        n_prev_l    = map_l;
                        n_prev_r    = map_r;
                        if (i_last_frame) begin
                            n_flush = 1'b1;
                            n_state = S_CHECK;
                        end
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_pos < ONE_POS) begin
                    n_state = S_ISSUE_L;
                end else if (!r_flush) begin
                    // interpolation done: advance to the current frame
                    n_pos    = r_pos - ONE_POS;
                    n_prev_l = r_cur_l;
                    n_prev_r = r_cur_r;
                    if (r_last) begin
                        n_flush = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    // flush done: restart the stream
                    n_have_prev = 1'b0;
                    n_pos       = '0;
                    n_prev_l    = '0;
                    n_prev_r    = '0;
                    n_flush     = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            S_ISSUE_L: begin
                n_state = S_ISSUE_R;
            end
            S_ISSUE_R: begin
                n_state = S_CAP_L;
            end
            S_CAP_L: begin
                n_res_l = lu_res;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld = 1'b1;
                    n_out_l   = r_res_l;
                    n_out_r   = r_out_stereo ? lu_res : '0;
                    n_out_rl  = fin;
                    n_out_se  = fin && r_last;
                    n_pos     = nxt_pos;
                    n_state   = S_CHECK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid  = r_out_vld;
    assign o_out_left   = r_out_l;
    assign o_out_right  = r_out_r;
    assign o_run_last   = r_out_rl;
    assign o_stream_end = r_out_se;

    // Checks
    `ASSERT_NOW(a_frac_in_range, (r_state == S_ISSUE_L || r_state == S_ISSUE_R),
                (r_pos < ONE_POS), "interpolation issued at a whole-frame position")
    `ASSERT_NOW(a_end_is_run_last, (r_out_vld && r_out_se), r_out_rl,
                "stream end without run last")
    `ASSERT_NOW(a_fresh_stream_pos, (in_acc && !r_have_prev), (r_pos == '0),
                "new stream starts at a nonzero position")
    `ASSERT_NEXT(a_flush_restarts, (r_state == S_CHECK && r_flush && r_pos >= ONE_POS),
                 (r_state == S_IDLE && !r_have_prev), "flush end did not restart the stream")

endmodule

// File: rtl/pcm_lrs_lerp.sv
// Shared two-stage interpolation unit: a + frac * (b - a), truncated toward zero.
// Stage one holds the product, stage two the scaled sum; no package dependency.
module pcm_lrs_lerp #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic signed [SAMPLE_BITS-1:0] i_a,
    input  logic signed [SAMPLE_BITS-1:0] i_b,
    input  logic        [FRAC_BITS-1:0]   i_frac,
    output logic signed [SAMPLE_BITS-1:0] o_res
);

    localparam int SB = SAMPLE_BITS;
    localparam int F  = FRAC_BITS;
    localparam int NW = SB + F + 2;

    logic signed [SB:0]    diff;
    logic signed [F:0]     frac_s;
    logic signed [NW-1:0]  n_prod;
    logic signed [NW-1:0]  r_prod;
    logic signed [SB-1:0]  r_a;
    logic                  r_s1_vld;
    logic signed [NW-1:0]  num;
    logic        [NW-1:0]  bias;
    logic        [NW-1:0]  adj;
    logic signed [SB-1:0]  r_res;

    // Stage one: difference times fraction
    assign diff   = {i_b[SB-1], i_b} - {i_a[SB-1], i_a};
    assign frac_s = {1'b0, i_frac};
    assign n_prod = diff * frac_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_prod <= n_prod;
            r_a    <= i_a;
        end
    end

    // Stage two: add the scaled base, bias negatives so the shift truncates toward zero
    assign num  = {{2{r_a[SB-1]}}, r_a, {F{1'b0}}} + r_prod;
    assign bias = {{(SB + 2){1'b0}}, {F{num[NW-1]}}};
    assign adj  = num + bias;

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_res <= adj[F+SB-1:F];
        end
    end

    assign o_res = r_res;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for pcm_channel_map_linear_resampler: channel mapping plus
// linear-interpolation resampling, checked word by word against a built-in predictor.
// Depends on pcm_lrs_pkg (register indexes) and the resampler RTL only.
`timescale 1ns / 1ps

module testbench;
    import pcm_lrs_pkg::*;

    localparam int     SAMPLE_W  = 16;
    localparam int     FRAC_W    = 16;
    localparam int     CFG_W     = FRAC_W + 4;
    localparam longint ONE_POS   = longint'(1) << FRAC_W;
    localparam longint STEP_MIN  = ONE_POS >> 3;
    localparam longint STEP_MAX  = ONE_POS << 3;
    localparam int     MAX_WORDS = 16;
    localparam int     RAND_WORDS = 480;
    localparam int     CALM_WORDS = 60;
    localparam int     SETTLE_CYCLES = 20;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       run_last;
        logic                       stream_end;
    } t_frame;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind                  kind;
        logic [CFG_IDX_W-1:0]       idx;
        logic [CFG_W-1:0]           data;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       last;
        int                         typed_n;   // -1: use predictor
        t_frame                     typed_res;
    } t_stim_row;

    // DUT ports
    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_idx;
    logic [CFG_W-1:0]           i_cfg_data;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_left_sample;
    logic signed [SAMPLE_W-1:0] i_right_sample;
    logic                       i_last_frame;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic signed [SAMPLE_W-1:0] o_out_left;
    logic signed [SAMPLE_W-1:0] o_out_right;
    logic                       o_run_last;
    logic                       o_stream_end;

    // Register mirror and resampler state of the predictor
    logic   cfg_in_stereo;
    logic   cfg_out_stereo;
    longint cfg_step;
    longint held_left;
    longint held_right;
    logic   holding;
    longint phase_pos;

    // Words the predictor produced for the current input word
    t_frame step_res[MAX_WORDS];
    int     step_count;

    t_frame    resampled_q[$];
    t_stim_row stim_rows[$];

    int   mismatches  = 0;
    int   words_taken = 0;
    logic calm        = 1'b0;
    logic held_off    = 1'b0;
    int   hold_left   = 0;
    int   burst_left  = 0;

    pcm_channel_map_linear_resampler dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_last_frame   (i_last_frame),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_left     (o_out_left),
        .o_out_right    (o_out_right),
        .o_run_last     (o_run_last),
        .o_stream_end   (o_stream_end)
    );

    always #1 i_clk = ~i_clk;

    // Interpolate between two samples, truncated toward zero
    function automatic longint lerp(input longint a, input longint b, input longint frac);
        return (a * ONE_POS + (b - a) * frac) / ONE_POS;
    endfunction

    task automatic store_result(input longint l, input longint r);
        step_res[step_count].left       = l[SAMPLE_W-1:0];
        step_res[step_count].right      = cfg_out_stereo ? r[SAMPLE_W-1:0] : '0;
        step_res[step_count].run_last   = 1'b0;
        step_res[step_count].stream_end = 1'b0;
        step_count++;
    endtask

    // Map channels, then emit every output position up to the new frame and flush the tail on a last frame
    task automatic resample_frame(input logic signed [SAMPLE_W-1:0] l,
                                  input logic signed [SAMPLE_W-1:0] r,
                                  input logic last);
        longint step;
        longint cl;
        longint cr;
        step = cfg_step;
        if (step < STEP_MIN) step = STEP_MIN;
        if (step > STEP_MAX) step = STEP_MAX;
        step_count = 0;

        if (cfg_in_stereo) begin
            if (cfg_out_stereo) begin
                cl = longint'(l);
                cr = longint'(r);
            end else begin
                cl = (longint'(l) + longint'(r)) / 2;
                cr = 0;
            end
        end else begin
            cl = longint'(l);
            cr = cfg_out_stereo ? longint'(l) : 0;
        end

        if (!holding) begin
            holding   = 1'b1;
            phase_pos = 0;
        end else begin
            while (phase_pos < ONE_POS && step_count < MAX_WORDS) begin
                store_result(lerp(held_left, cl, phase_pos), lerp(held_right, cr, phase_pos));
                phase_pos += step;
            end
            phase_pos = (phase_pos >= ONE_POS) ? phase_pos - ONE_POS : 0;
        end
        held_left  = cl;
        held_right = cr;

        // Flush the tail flat and restart the stream
        if (last) begin
            while (phase_pos < ONE_POS && step_count < MAX_WORDS) begin
                store_result(cl, cr);
                phase_pos += step;
            end
            if (step_count > 0) step_res[step_count-1].stream_end = 1'b1;
            held_left  = 0;
            held_right = 0;
            holding    = 1'b0;
            phase_pos  = 0;
        end
        if (step_count > 0) step_res[step_count-1].run_last = 1'b1;
    endtask

    // Hold the input side until the block has drained, then write one register
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (resampled_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_IN_STEREO:  cfg_in_stereo  = data[0];
            CFG_OUT_STEREO: cfg_out_stereo = data[0];
            CFG_PHASE_INC:  cfg_step       = longint'(data);
            default: ;
        endcase
    endtask

    // Offer one word, wait for acceptance, queue what it should produce
    task automatic offer_word(input logic signed [SAMPLE_W-1:0] l,
                              input logic signed [SAMPLE_W-1:0] r,
                              input logic last, input int typed_n, input t_frame typed_res);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_left_sample  = l;
        i_right_sample = r;
        i_last_frame   = last;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        words_taken++;
        resample_frame(l, r, last);
        if (typed_n < 0) begin
            for (int k = 0; k < step_count; k++) resampled_q.push_back(step_res[k]);
        end else if (typed_n > 0) begin
            resampled_q.push_back(typed_res);
        end
    endtask

    function automatic void add_word(input int l, input int r, input logic last,
                                     input int typed_n = -1, input int el = 0,
                                     input int er = 0, input logic erl = 1'b0,
                                     input logic ese = 1'b0);
        t_stim_row row;
        row.kind      = ROW_WORD;
        row.idx       = '0;
        row.data      = '0;
        row.left      = l[SAMPLE_W-1:0];
        row.right     = r[SAMPLE_W-1:0];
        row.last      = last;
        row.typed_n   = typed_n;
        row.typed_res = '{left: el[SAMPLE_W-1:0], right: er[SAMPLE_W-1:0],
                          run_last: erl, stream_end: ese};
        stim_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input int data);
        t_stim_row row;
        row.kind      = ROW_CFG;
        row.idx       = idx;
        row.data      = data[CFG_W-1:0];
        row.left      = '0;
        row.right     = '0;
        row.last      = 1'b0;
        row.typed_n   = -1;
        row.typed_res = '0;
        stim_rows.push_back(row);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return SAMPLE_W'($urandom_range(0, 64)) - 16'sd32;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_step();
        case ($urandom_range(0, 9))
            0:       return CFG_W'(STEP_MIN);
            1:       return CFG_W'(STEP_MAX);
            2:       return CFG_W'($urandom_range(0, 32'(STEP_MIN - 1)));
            3:       return CFG_W'($urandom_range(32'(STEP_MAX + 1), (1 << CFG_W) - 1));
            4, 5, 6: return CFG_W'($urandom_range(32'(STEP_MIN), 32'(2 * ONE_POS)));
            default: return CFG_W'($urandom_range(32'(ONE_POS / 2), 32'(STEP_MAX)));
        endcase
    endfunction

    // Compare one field of an output word
    function automatic void check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    // Check every accepted output word against the oldest expectation
    always @(posedge i_clk) begin
        t_frame exp_w;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (resampled_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %0d/%0d", $time,
                         o_out_left, o_out_right);
                mismatches++;
            end else begin
                exp_w = resampled_q.pop_front();
                check_field("out_left", exp_w.left, o_out_left);
                check_field("out_right", exp_w.right, o_out_right);
                check_field("run_last", exp_w.run_last, o_run_last);
                check_field("stream_end", exp_w.stream_end, o_stream_end);
            end
        end
    end

    // Output back-pressure: short random bursts, one long hold-off, none at the end
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_off && words_taken >= 120 && i_in_valid === 1'b1) begin
                held_off  = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall = 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                i_out_stall = 1'b1;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                burst_left  = $urandom_range(1, 4) - 1;
                i_out_stall = 1'b1;
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    // Hard stop
    initial begin
        #1_000_000;
        $display("pcm_channel_map_linear_resampler: mismatch");
        $finish;
    end

    initial begin
        int     sent;
        int     len;
        int     waited;
        logic   broken;
        t_frame none;
        none = '0;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_left_sample  = '0;
        i_right_sample = '0;
        i_last_frame   = 1'b0;

        cfg_in_stereo  = 1'b0;
        cfg_out_stereo = 1'b0;
        cfg_step       = ONE_POS;
        held_left      = 0;
        held_right     = 0;
        holding        = 1'b0;
        phase_pos      = 0;

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset defaults, a single-word stream flushed flat
        add_word(32767, 0, 1'b1, 1, 32767, 0, 1'b1, 1'b1);
        // first word is only stored, the next one returns it exactly
        add_word(-32768, 1234, 1'b0, 0);
        add_word(32767, 0, 1'b0, 1, -32768, 0, 1'b1, 1'b0);
        add_word(0, 0, 1'b1);
        // stereo through at the smallest step: full-scale swings, sixteen-word item
        add_cfg(CFG_IN_STEREO, 1);
        add_cfg(CFG_OUT_STEREO, 1);
        add_cfg(CFG_PHASE_INC, 32'(STEP_MIN));
        add_word(32767, -32768, 1'b0, 0);
        add_word(-32768, 32767, 1'b0);
        add_word(-32768, -32768, 1'b1);
        // stereo down to mono, step below range gets clamped; odd negative sums
        add_cfg(CFG_OUT_STEREO, 0);
        add_cfg(CFG_PHASE_INC, 0);
        add_word(32767, 32767, 1'b0, 0);
        add_word(-32768, -1, 1'b0);
        add_word(-3, 0, 1'b1);
        // mono up to stereo, step above range: words with no output, silent end
        add_cfg(CFG_IN_STEREO, 0);
        add_cfg(CFG_OUT_STEREO, 1);
        add_cfg(CFG_PHASE_INC, 32'hFFFFF);
        add_word(-1, 12345, 1'b0, 0);
        add_word(100, 7, 1'b0, 1, -1, -1, 1'b1, 1'b0);
        add_word(5, 5, 1'b0, 0);
        add_word(200, 0, 1'b1, 0);
        // change mode mid-stream: the held frame keeps its mono form
        add_cfg(CFG_OUT_STEREO, 0);
        add_cfg(CFG_PHASE_INC, 32'(STEP_MAX));
        add_word(1000, -5, 1'b0, 0);
        add_cfg(CFG_IN_STEREO, 1);
        add_cfg(CFG_OUT_STEREO, 1);
        add_cfg(CFG_PHASE_INC, 32'(ONE_POS));
        add_word(2000, -2000, 1'b1);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_CFG)
                write_reg(stim_rows[i].idx, stim_rows[i].data);
            else
                offer_word(stim_rows[i].left, stim_rows[i].right, stim_rows[i].last,
                           stim_rows[i].typed_n, stim_rows[i].typed_res);
        end

        // Random streams, most under new settings; some end without a last frame
        sent = 0;
        while (sent < RAND_WORDS) begin
            if ($urandom_range(0, 3) != 0) begin
                write_reg(CFG_IN_STEREO, CFG_W'($urandom_range(0, 1)));
                write_reg(CFG_OUT_STEREO, CFG_W'($urandom_range(0, 1)));
                write_reg(CFG_PHASE_INC, pick_step());
            end
            len    = $urandom_range(1, 24);
            broken = ($urandom_range(0, 5) == 0);
            for (int k = 0; k < len; k++) begin
                calm = (sent >= RAND_WORDS - CALM_WORDS);
                offer_word(pick_sample(), pick_sample(),
                           (k == len - 1) ? !broken : ($urandom_range(0, 40) == 0),
                           -1, none);
                sent++;
            end
        end

        // Drain
        @(negedge i_clk);
        i_in_valid = 1'b0;
        waited = 0;
        while (resampled_q.size() != 0 && waited < 5000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (resampled_q.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, resampled_q.size());
            mismatches++;
        end

        if (mismatches == 0)
            $display("pcm_channel_map_linear_resampler: match");
        else
            $display("pcm_channel_map_linear_resampler: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/pcm_lrs_pkg.sv
rtl/pcm_lrs_lerp.sv
rtl/pcm_channel_map_linear_resampler.sv
tb/testbench.sv
